[src/crb_pkg.sv]
// Shared types and constants for the crop and bilinear resize block.
// No dependencies; every other file refers to this package by scoped name.
package crb_pkg;

  localparam int POS_W    = 9;
  localparam int START_W  = 9;
  localparam int SIZE_W   = 10;
  localparam int COORD_W  = 11;
  localparam int WEIGHT_W = 9;
  localparam int OFFSET_W = 18;
  localparam int FRAC_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [SIZE_W-1:0]  SIZE_RESET  = 10'd512;
  localparam logic [START_W-1:0] START_RESET = 9'd0;
  localparam logic [SIZE_W-1:0]  MIN_CROP    = 10'd2;

  typedef enum logic {
    CMD_WRITE   = 1'b0,
    CMD_COMPUTE = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_CROP_LEFT  = 3'd2,
    REG_CROP_TOP   = 3'd3,
    REG_CROP_WIDTH = 3'd4,
    REG_CROP_HEIGHT = 3'd5
  } cfg_reg_e;

  // index 2 red, 1 green, 0 blue
  typedef logic [2:0][7:0] pixel_t;

  typedef struct packed {
    logic [COORD_W-1:0]  base;
    logic [WEIGHT_W-1:0] weight;
  } axis_t;

  typedef struct packed {
    logic               we;
    logic               re;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    pixel_t             data;
  } store_req_t;

  typedef struct packed {
    logic take_left;
    logic row;
    logic first;
    logic acc;
  } blend_ctl_t;

endpackage

[src/crb_if.sv]
// Handshake channels of the crop and bilinear resize block: config, input, output.
// Depends on crb_pkg for field widths.
interface crb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [crb_pkg::CFG_IDX_W-1:0]   index;
  logic [crb_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface crb_in_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [crb_pkg::POS_W-1:0]    x_pos;
  logic [crb_pkg::POS_W-1:0]    y_pos;
  logic [7:0]                   in_red;
  logic [7:0]                   in_green;
  logic [7:0]                   in_blue;

  modport source (output valid, output command, output x_pos, output y_pos,
                  output in_red, output in_green, output in_blue, input ready);
  modport sink (input valid, input command, input x_pos, input y_pos,
                input in_red, input in_green, input in_blue, output ready);
endinterface

interface crb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       region_error;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output region_error, input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                input region_error, output ready);
endinterface

[src/crb_store.sv]
// Single-port pixel memory, one 24-bit RGB entry per source pixel, registered read.
// Depends on crb_pkg (store_req_t, pixel_t).
module crb_store #(
  parameter int MAX_SRC_WIDTH  = 512,
  parameter int MAX_SRC_HEIGHT = 512
) (
  input  logic                clk_i,
  input  crb_pkg::store_req_t req_i,
  output crb_pkg::pixel_t     rdata_o
);

  localparam int Depth = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int AddrW = $clog2(Depth);

  crb_pkg::pixel_t mem [Depth];
  crb_pkg::pixel_t rdata_q;
  logic [AddrW-1:0] addr;
  logic             in_range;

  assign addr = AddrW'(int'(req_i.y) * MAX_SRC_WIDTH + int'(req_i.x));
  assign in_range = (int'(req_i.x) < MAX_SRC_WIDTH) && (int'(req_i.y) < MAX_SRC_HEIGHT);

  always_ff @(posedge clk_i) begin
    if (req_i.we && in_range) begin
      mem[addr] <= req_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/crb_axis_map.sv]
// Maps one output coordinate into the crop window: base pixel and 9-bit weight.
// Three register stages; divide by OUT_SIZE via reciprocal multiply. Uses crb_pkg.
module crb_axis_map #(
  parameter int OUT_SIZE = 224
) (
  input  logic                          clk_i,
  input  logic                          load_i,
  input  logic [crb_pkg::POS_W-1:0]     pos_i,
  input  logic [crb_pkg::START_W-1:0]   start_i,
  input  logic [crb_pkg::SIZE_W-1:0]    size_i,
  output crb_pkg::axis_t                axis_o
);

  localparam int ProdW      = crb_pkg::POS_W + crb_pkg::SIZE_W;
  localparam int NumW       = ProdW + crb_pkg::FRAC_W;
  localparam int RecipW     = NumW + 2;
  localparam int QuotW      = ProdW + RecipW;
  localparam int RecipShift = NumW + $clog2(OUT_SIZE);
  localparam int QShift     = RecipShift - crb_pkg::FRAC_W;
  localparam logic [63:0] RecipPow = 64'd1 << RecipShift;
  localparam logic [RecipW-1:0] Recip =
      RecipW'((RecipPow + 64'(OUT_SIZE) - 64'd1) / 64'(OUT_SIZE));

  logic [ProdW-1:0]              prod_q;
  logic [QuotW-1:0]              quot_q;
  logic [crb_pkg::OFFSET_W-1:0]  offset;
  logic [crb_pkg::SIZE_W-1:0]    rel_raw;
  logic [crb_pkg::SIZE_W-1:0]    rel;
  crb_pkg::axis_t                axis_d;
  crb_pkg::axis_t                axis_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= ProdW'(pos_i) * ProdW'(size_i);
    end
    quot_q <= QuotW'(prod_q) * QuotW'(Recip);
    axis_q <= axis_d;
  end

  // exact floor(prod * 256 / OUT_SIZE) for all numerators below 2^NumW
  assign offset  = quot_q[QShift +: crb_pkg::OFFSET_W];
  assign rel_raw = offset[crb_pkg::OFFSET_W-1 -: crb_pkg::SIZE_W];

  always_comb begin
    if (rel_raw >= size_i - crb_pkg::SIZE_W'(1)) begin
      rel = size_i - crb_pkg::SIZE_W'(2);
    end else begin
      rel = rel_raw;
    end
    axis_d.base   = crb_pkg::COORD_W'(start_i) + crb_pkg::COORD_W'(rel);
    axis_d.weight = crb_pkg::WEIGHT_W'(offset - {rel, {crb_pkg::FRAC_W{1'b0}}});
  end

  assign axis_o = axis_q;

endmodule

[src/crb_blend.sv]
// Bilinear blend datapath, three color lanes: row blend, vertical accumulate, clamp.
// Sequenced by crb_pkg::blend_ctl_t from the top level.
module crb_blend (
  input  logic                           clk_i,
  input  crb_pkg::blend_ctl_t            ctl_i,
  input  crb_pkg::pixel_t                rdata_i,
  input  logic [crb_pkg::WEIGHT_W-1:0]   wx_i,
  input  logic [crb_pkg::WEIGHT_W-1:0]   wy_i,
  output crb_pkg::pixel_t                pix_o
);

  crb_pkg::pixel_t    left_q;
  logic signed [19:0] row_q [3];
  logic signed [30:0] acc_q [3];
  logic signed [9:0]  wx_s;
  logic signed [9:0]  inv_x;
  logic signed [9:0]  wy_s;
  logic signed [9:0]  inv_y;
  logic signed [9:0]  fy;

  assign wx_s  = $signed({1'b0, wx_i});
  assign inv_x = 10'sd256 - wx_s;
  assign wy_s  = $signed({1'b0, wy_i});
  assign inv_y = 10'sd256 - wy_s;
  assign fy    = ctl_i.acc ? wy_s : inv_y;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      if (ctl_i.take_left) begin
        left_q[c] <= rdata_i[c];
      end
      if (ctl_i.row) begin
        row_q[c] <= $signed({1'b0, left_q[c]}) * inv_x + $signed({1'b0, rdata_i[c]}) * wx_s;
      end
      if (ctl_i.first || ctl_i.acc) begin
        acc_q[c] <= (ctl_i.acc ? acc_q[c] : 31'sd0) + row_q[c] * fy;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (acc_q[c][30]) begin
        pix_o[c] = 8'd0;
      end else if (|acc_q[c][29:24]) begin
        pix_o[c] = 8'd255;
      end else begin
        pix_o[c] = acc_q[c][23:16];
      end
    end
  end

endmodule

[src/crop_bilinear_resize.sv]
// Crop and bilinear resize: top level with config registers, sequencer and output register.
// Uses crb_pkg, crb_if, crb_store, crb_axis_map, crb_blend.
//
//   channel  dir  payload                                   transfer
//   cfg_ch   in   index, data                               valid & ready (ready always 1)
//   in_ch    in   command, x_pos, y_pos, in_red/green/blue  valid & ready
//   out_ch   out  out_red, out_green, out_blue, region_error valid & ready
//
// Write: one per cycle, stored at the transfer edge, no result.
// Compute: result registered in S_DONE after MAP1, MAP2, RD0 to RD3, ROW1 and SUM (directly
//   when the region is bad), next in_ch transfer once the result leaves S_DONE: two
//   multiply stages map the coordinates, then four reads of the single-port pixel memory.
// in_ch is not ready during a compute; a stalled result holds only the last step.
// Reset clears control state and config; the pixel memory is not cleared.
module crop_bilinear_resize #(
  parameter int MAX_SRC_WIDTH  = 512,
  parameter int MAX_SRC_HEIGHT = 512,
  parameter int OUT_SIZE       = 224
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  crb_cfg_if.sink     cfg_ch,
  crb_in_if.sink      in_ch,
  crb_out_if.source   out_ch
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_MAP1 = 10'b00_0000_0010,
    S_MAP2 = 10'b00_0000_0100,
    S_RD0  = 10'b00_0000_1000,
    S_RD1  = 10'b00_0001_0000,
    S_RD2  = 10'b00_0010_0000,
    S_RD3  = 10'b00_0100_0000,
    S_ROW1 = 10'b00_1000_0000,
    S_SUM  = 10'b01_0000_0000,
    S_DONE = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [crb_pkg::SIZE_W-1:0]  src_w_q, src_h_q, crop_w_q, crop_h_q;
  logic [crb_pkg::START_W-1:0] crop_left_q, crop_top_q;

  logic                   in_acc, is_compute, region_bad, bad_q, out_free, out_load;
  logic                   out_valid_q, out_err_q;
  crb_pkg::pixel_t        out_pix_q, blend_pix, rdata;
  logic [crb_pkg::POS_W-1:0] pos_x, pos_y;
  logic [10:0]            right_end, bottom_end;
  crb_pkg::axis_t         ax, ay;
  crb_pkg::store_req_t    req;
  crb_pkg::blend_ctl_t    ctl;

  // config port
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q     <= crb_pkg::SIZE_RESET;
      src_h_q     <= crb_pkg::SIZE_RESET;
      crop_left_q <= crb_pkg::START_RESET;
      crop_top_q  <= crb_pkg::START_RESET;
      crop_w_q    <= crb_pkg::SIZE_RESET;
      crop_h_q    <= crb_pkg::SIZE_RESET;
    end else if (cfg_ch.valid) begin
      unique case (crb_pkg::cfg_reg_e'(cfg_ch.index))
        crb_pkg::REG_SRC_WIDTH:   src_w_q     <= cfg_ch.data;
        crb_pkg::REG_SRC_HEIGHT:  src_h_q     <= cfg_ch.data;
        crb_pkg::REG_CROP_LEFT:   crop_left_q <= cfg_ch.data[crb_pkg::START_W-1:0];
        crb_pkg::REG_CROP_TOP:    crop_top_q  <= cfg_ch.data[crb_pkg::START_W-1:0];
        crb_pkg::REG_CROP_WIDTH:  crop_w_q    <= cfg_ch.data;
        crb_pkg::REG_CROP_HEIGHT: crop_h_q    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign right_end  = 11'(crop_left_q) + 11'(crop_w_q);
  assign bottom_end = 11'(crop_top_q) + 11'(crop_h_q);
  assign region_bad = (crop_w_q < crb_pkg::MIN_CROP) || (crop_h_q < crb_pkg::MIN_CROP) ||
                      (right_end > 11'(src_w_q)) || (bottom_end > 11'(src_h_q)) ||
                      (int'(src_w_q) > MAX_SRC_WIDTH) || (int'(src_h_q) > MAX_SRC_HEIGHT);

  // input side
  assign in_ch.ready = (state_q == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_compute  = (in_ch.command == crb_pkg::CMD_COMPUTE);

  assign pos_x = (int'(in_ch.x_pos) >= OUT_SIZE) ? crb_pkg::POS_W'(OUT_SIZE - 1) : in_ch.x_pos;
  assign pos_y = (int'(in_ch.y_pos) >= OUT_SIZE) ? crb_pkg::POS_W'(OUT_SIZE - 1) : in_ch.y_pos;

  crb_axis_map #(.OUT_SIZE(OUT_SIZE)) u_map_x (
    .clk_i   (clk_i),
    .load_i  (in_acc && is_compute),
    .pos_i   (pos_x),
    .start_i (crop_left_q),
    .size_i  (crop_w_q),
    .axis_o  (ax)
  );

  crb_axis_map #(.OUT_SIZE(OUT_SIZE)) u_map_y (
    .clk_i   (clk_i),
    .load_i  (in_acc && is_compute),
    .pos_i   (pos_y),
    .start_i (crop_top_q),
    .size_i  (crop_h_q),
    .axis_o  (ay)
  );

  // sequencer
  assign out_free = !out_valid_q || out_ch.ready;
  assign out_load = (state_q == S_DONE) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && is_compute) begin
          state_d = region_bad ? S_DONE : S_MAP1;
        end
      end
      S_MAP1: state_d = S_MAP2;
      S_MAP2: state_d = S_RD0;
      S_RD0:  state_d = S_RD1;
      S_RD1:  state_d = S_RD2;
      S_RD2:  state_d = S_RD3;
      S_RD3:  state_d = S_ROW1;
      S_ROW1: state_d = S_SUM;
      S_SUM:  state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_compute) begin
      bad_q <= region_bad;
    end
  end

  // memory access: port writes while idle, neighbor reads during a compute
  always_comb begin
    req = '0;
    if (state_q == S_IDLE) begin
      req.we   = in_acc && !is_compute;
      req.x    = crb_pkg::COORD_W'(in_ch.x_pos);
      req.y    = crb_pkg::COORD_W'(in_ch.y_pos);
      req.data = {in_ch.in_red, in_ch.in_green, in_ch.in_blue};
    end else begin
      req.re = (state_q == S_RD0) || (state_q == S_RD1) ||
               (state_q == S_RD2) || (state_q == S_RD3);
      req.x  = ax.base + crb_pkg::COORD_W'((state_q == S_RD1) || (state_q == S_RD3));
      req.y  = ay.base + crb_pkg::COORD_W'((state_q == S_RD2) || (state_q == S_RD3));
    end
  end

  crb_store #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
  ) u_store (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  always_comb begin
    ctl.take_left = (state_q == S_RD1) || (state_q == S_RD3);
    ctl.row       = (state_q == S_RD2) || (state_q == S_ROW1);
    ctl.first     = (state_q == S_RD3);
    ctl.acc       = (state_q == S_SUM);
  end

  crb_blend u_blend (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .rdata_i (rdata),
    .wx_i    (ax.weight),
    .wy_i    (ay.weight),
    .pix_o   (blend_pix)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pix_q <= bad_q ? '0 : blend_pix;
      out_err_q <= bad_q;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.out_red      = out_pix_q[2];
  assign out_ch.out_green    = out_pix_q[1];
  assign out_ch.out_blue     = out_pix_q[0];
  assign out_ch.region_error = out_err_q;

`ifndef SYNTHESIS
  a_compute_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (in_acc && is_compute) |=> (state_q == S_MAP1 || state_q == S_DONE))
    else $error("compute transfer did not start the sequence");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_q && out_err_q) |-> (out_pix_q == '0))
    else $error("region error result carries nonzero color");

  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (in_acc && !is_compute && !out_valid_q) |=> !out_valid_q)
    else $error("write transfer produced a result");
`endif

endmodule
